// ----- design/cng_pkg.sv -----
// ============================================================================
// cng_pkg: shared types and constants for the colored noise generator
// LCG constants, value limits, opcodes, sequencer states and the trailing-zero
// count used to pick the pink-noise octave.
// ============================================================================
package cng_pkg;

    // LCG step: state = state * LCG_MUL + LCG_ADD (mod 2^32)
    localparam logic [31:0] LCG_MUL = 32'd196314165;
    localparam logic [31:0] LCG_ADD = 32'd907633515;

    // Q1.22 offset that centers the top 23 LCG bits
    localparam int HALF_RANGE  = 4194304;
    // Inclusive limits of the running sums (Q.22)
    localparam int PINK_LIMIT  = 4 * 4194304;
    localparam int BROWN_LIMIT = 8 * 4194304;
    // Largest positive Q.26 sample
    localparam int SAMPLE_MAX  = 536870911;

    // Register map: index taken from paddr[2]
    localparam logic        REG_FALLBACK_SEED = 1'b0;
    localparam logic [31:0] FALLBACK_RESET    = 32'd1;

    typedef enum logic [1:0] {
        OP_WHITE = 2'd0,
        OP_PINK  = 2'd1,
        OP_BROWN = 2'd2,
        OP_SEED  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADV,
        ST_WMUL,
        ST_WOUT,
        ST_PCHK,
        ST_POUT,
        ST_BCHK,
        ST_DONE
    } state_t;

    // Count trailing zeros of a 32-bit word by halving search; zero gives 32
    function automatic logic [5:0] tz32(input logic [31:0] x);
        logic [31:0] v;
        logic [5:0]  n;
        v = x;
        n = 6'd0;
        if (v == 32'd0) begin
            n = 6'd32;
        end else begin
            if (v[15:0] == 16'd0) begin
                n = n + 6'd16;
                v = v >> 16;
            end
            if (v[7:0] == 8'd0) begin
                n = n + 6'd8;
                v = v >> 8;
            end
            if (v[3:0] == 4'd0) begin
                n = n + 6'd4;
                v = v >> 4;
            end
            if (v[1:0] == 2'd0) begin
                n = n + 6'd2;
                v = v >> 2;
            end
            if (v[0] == 1'b0) begin
                n = n + 6'd1;
            end
        end
        return n;
    endfunction

endpackage

// ----- design/colored_noise_generator_unit.sv -----
// ============================================================================
// colored_noise_generator_unit: white, pink and brown noise from a 32-bit LCG
// One shared signed multiplier serves both the LCG step and the white-noise
// gain; a small sequencer runs draws, range checks and redraws.
// ============================================================================
// Each LCG draw is a multiply, then an add, then a range check; the white draw
// goes on to the gain multiply and rounding, and the pink output draw to the
// output sum, instead of a check. Brown and pink redraw until the check passes.
// Seed load: accepted, no result. One transaction in flight at a time;
// a stalled result adds its wait, and the next transaction is taken once
// the result is registered.
// Reset (aresetn low, synchronous) clears the LCG, sums and octave table,
// sets the octave counter to 1 and the fallback seed to 1.
module colored_noise_generator_unit #(
    parameter int OCTAVES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input transactions
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic signed [15:0] s_gain,
    input  logic [31:0]        s_seed_value,
    // result transactions
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [29:0] m_sample,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IDX_W = $clog2(OCTAVES);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    cng_pkg::state_t    state_reg, state_next;
    cng_pkg::op_t       op_reg, op_next;
    logic signed [15:0] gain_reg, gain_next;
    logic               final_reg, final_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic signed [23:0] prev_reg, prev_next;
    logic [31:0]        lcg_reg, lcg_next;
    logic [31:0]        cnt_reg, cnt_next;
    logic signed [25:0] pink_sum_reg, pink_sum_next;
    logic signed [26:0] brown_sum_reg, brown_sum_next;
    logic signed [61:0] prod_reg, prod_next;
    logic signed [29:0] res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [29:0] m_sample_reg, m_sample_next;
    logic [31:0]        fallback_seed_reg;
    logic signed [23:0] octave_reg [OCTAVES];
    logic               oct_we;

    // ------------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------------
    logic signed [23:0] white_val;
    logic signed [32:0] mul_a;
    logic signed [28:0] mul_b;
    logic signed [61:0] mul_p;
    logic [5:0]         tz_val;
    logic [5:0]         tz_idx;
    logic signed [39:0] round_sum;
    logic signed [31:0] white_r;
    logic signed [26:0] pink_try;
    logic signed [27:0] pink_out;
    logic signed [27:0] brown_try;
    logic               accept;
    logic               cfg_write;

    // Center the top 23 LCG bits: exact Q1.22 value in [-1,1)
    assign white_val = $signed({1'b0, lcg_reg[31:9]}) - 24'(cng_pkg::HALF_RANGE);

    // Shared multiplier: LCG step or white gain, picked by the sequencer
    always_comb begin
        if (state_reg == cng_pkg::ST_WMUL) begin
            mul_a = {{9{white_val[23]}}, white_val};
            mul_b = {{13{gain_reg[15]}}, gain_reg};
        end else begin
            mul_a = {1'b0, lcg_reg};
            mul_b = {1'b0, cng_pkg::LCG_MUL[27:0]};
        end
    end
    assign mul_p = mul_a * mul_b;

    // Octave index from the trailing zeros of the counter
    assign tz_val = cng_pkg::tz32(cnt_reg);
    assign tz_idx = tz_val & 6'(OCTAVES - 1);

    // White rounding: add half an LSB, floor shift by 8
    assign round_sum = prod_reg[39:0] + 40'sd128;
    assign white_r   = round_sum[39:8];

    // Candidate sums
    assign pink_try  = {pink_sum_reg[25], pink_sum_reg}
                     + {{3{white_val[23]}}, white_val}
                     - {{3{prev_reg[23]}}, prev_reg};
    assign pink_out  = {{2{pink_sum_reg[25]}}, pink_sum_reg}
                     + {{4{white_val[23]}}, white_val};
    assign brown_try = {brown_sum_reg[26], brown_sum_reg}
                     + {{4{white_val[23]}}, white_val};

    assign accept    = s_valid && s_ready;
    assign cfg_write = psel && penable && pwrite && pready;

    // ------------------------------------------------------------------------
    // Sequencer: next state and datapath updates
    // ------------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        gain_next      = gain_reg;
        final_next     = final_reg;
        k_next         = k_reg;
        prev_next      = prev_reg;
        lcg_next       = lcg_reg;
        cnt_next       = cnt_reg;
        pink_sum_next  = pink_sum_reg;
        brown_sum_next = brown_sum_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_sample_next  = m_sample_reg;
        oct_we         = 1'b0;

        // drop the result once it is taken
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            cng_pkg::ST_IDLE: begin
                if (accept) begin
                    op_next    = cng_pkg::op_t'(s_op);
                    gain_next  = s_gain;
                    final_next = 1'b0;
                    k_next     = tz_idx[IDX_W-1:0];
                    prev_next  = octave_reg[tz_idx[IDX_W-1:0]];
                    if (cng_pkg::op_t'(s_op) == cng_pkg::OP_SEED) begin
                        lcg_next = (s_seed_value != 32'd0) ? s_seed_value
                                                           : fallback_seed_reg;
                    end else begin
                        state_next = cng_pkg::ST_MUL;
                    end
                end
            end
            cng_pkg::ST_MUL: begin
                prod_next  = mul_p;
                state_next = cng_pkg::ST_ADV;
            end
            cng_pkg::ST_ADV: begin
                lcg_next = prod_reg[31:0] + cng_pkg::LCG_ADD;
                unique case (op_reg)
                    cng_pkg::OP_WHITE: state_next = cng_pkg::ST_WMUL;
                    cng_pkg::OP_PINK:  state_next = final_reg ? cng_pkg::ST_POUT
                                                              : cng_pkg::ST_PCHK;
                    cng_pkg::OP_BROWN: state_next = cng_pkg::ST_BCHK;
                    cng_pkg::OP_SEED:  state_next = cng_pkg::ST_IDLE;
                endcase
            end
            cng_pkg::ST_WMUL: begin
                prod_next  = mul_p;
                state_next = cng_pkg::ST_WOUT;
            end
            cng_pkg::ST_WOUT: begin
                // saturate the single overflow case (-1 times -8)
                if (white_r > 32'(cng_pkg::SAMPLE_MAX)) begin
                    res_next = 30'(cng_pkg::SAMPLE_MAX);
                end else begin
                    res_next = white_r[29:0];
                end
                state_next = cng_pkg::ST_DONE;
            end
            cng_pkg::ST_PCHK: begin
                // every attempt overwrites the octave entry
                oct_we = 1'b1;
                if (pink_try >= -27'(cng_pkg::PINK_LIMIT) &&
                    pink_try <= 27'(cng_pkg::PINK_LIMIT)) begin
                    pink_sum_next = pink_try[25:0];
                    cnt_next      = cnt_reg + 32'd1;
                    final_next    = 1'b1;
                end
                state_next = cng_pkg::ST_MUL;
            end
            cng_pkg::ST_POUT: begin
                res_next   = {pink_out[27], pink_out, 1'b0};
                state_next = cng_pkg::ST_DONE;
            end
            cng_pkg::ST_BCHK: begin
                if (brown_try >= -28'(cng_pkg::BROWN_LIMIT) &&
                    brown_try <= 28'(cng_pkg::BROWN_LIMIT)) begin
                    brown_sum_next = brown_try[26:0];
                    res_next       = {{3{brown_try[26]}}, brown_try[26:0]};
                    state_next     = cng_pkg::ST_DONE;
                end else begin
                    state_next = cng_pkg::ST_MUL;
                end
            end
            cng_pkg::ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = res_reg;
                    state_next    = cng_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cng_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // State register
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cng_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ------------------------------------------------------------------------
    // Generator state, sums and octave table
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcg_reg           <= 32'd0;
            cnt_reg           <= 32'd1;
            pink_sum_reg      <= '0;
            brown_sum_reg     <= '0;
            fallback_seed_reg <= cng_pkg::FALLBACK_RESET;
            for (int i = 0; i < OCTAVES; i++) begin
                octave_reg[i] <= '0;
            end
        end else begin
            lcg_reg       <= lcg_next;
            cnt_reg       <= cnt_next;
            pink_sum_reg  <= pink_sum_next;
            brown_sum_reg <= brown_sum_next;
            if (cfg_write && paddr[2] == cng_pkg::REG_FALLBACK_SEED) begin
                fallback_seed_reg <= pwdata;
            end
            if (oct_we) begin
                octave_reg[k_reg] <= white_val;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        gain_reg     <= gain_next;
        final_reg    <= final_next;
        k_reg        <= k_next;
        prev_reg     <= prev_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
        m_sample_reg <= m_sample_next;
    end

    // ------------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------------
    assign s_ready  = (state_reg == cng_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == cng_pkg::REG_FALLBACK_SEED) ? fallback_seed_reg : 32'd0;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_pink_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pink_sum_reg >= -cng_pkg::PINK_LIMIT) && (pink_sum_reg <= cng_pkg::PINK_LIMIT))
        else $error("pink sum left its range");

    a_brown_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (brown_sum_reg >= -cng_pkg::BROWN_LIMIT) && (brown_sum_reg <= cng_pkg::BROWN_LIMIT))
        else $error("brown sum left its range");

    a_seed_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_op == cng_pkg::OP_SEED) |=>
        (lcg_reg == (($past(s_seed_value) != 32'd0) ? $past(s_seed_value)
                                                     : $past(fallback_seed_reg))))
        else $error("seed transaction did not load the generator");

    a_counter_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (cnt_reg != $past(cnt_reg))) |->
        ($past(state_reg) == cng_pkg::ST_PCHK))
        else $error("octave counter moved outside a pink check");

endmodule
